// ===== rtl/core/hcpg_pkg.sv =====
// Package for the coupled Hopf pattern generator: sizes, codes, FSM types
// and the elaboration-time sigmoid table. No dependencies.
`timescale 1ns / 1ps

package hcpg_pkg;

  localparam int NUM_OSC         = 6;
  localparam int SIGMOID_ENTRIES = 256;

  localparam int OP_W   = 2;
  localparam int ROW_W  = 3;
  localparam int VAL_W  = 32;
  localparam int CIDX_W = 2;
  localparam int CDAT_W = 24;

  localparam int OSC_IW   = $clog2(NUM_OSC);
  localparam int ST_DEPTH = 2 * NUM_OSC;
  localparam int ST_AW    = $clog2(ST_DEPTH);
  localparam int CP_DEPTH = NUM_OSC * NUM_OSC;
  localparam int CP_AW    = $clog2(CP_DEPTH);
  localparam int SIG_AW   = $clog2(SIGMOID_ENTRIES);

  localparam int DIV_NW = 48;
  localparam int DIV_DW = 16;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  localparam logic [27:0] THREE_PI_Q24 = 28'd158121536;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_COUPLE = 2'd1;
  localparam logic [OP_W-1:0] OP_STATE  = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_SWING = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_DUTY  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_STEP  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DIV, S_SELF_RD, S_SELF_LT, S_CALC, S_CP_RD,
    S_CP_LT, S_CP_MUL, S_FIN, S_H_MUL, S_SUM, S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    MOP_NONE, MOP_XX, MOP_YY, MOP_WST, MOP_WSW, MOP_AX, MOP_AY, MOP_WY,
    MOP_WX, MOP_CX, MOP_SY, MOP_SX, MOP_CY, MOP_DXH_HI, MOP_DXH_LO,
    MOP_DYH_HI, MOP_DYH_LO
  } mul_op_t;

  typedef logic [24:0] sig_table_t [SIGMOID_ENTRIES];

  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Bin-centre logistic values, Q1.24; exp via Taylor of exp(-|z|/256) squared 8 times
  function automatic sig_table_t sig_table_f();
    sig_table_t tab;
    logic signed [63:0] zc;
    logic [63:0] a, d, t2, t3, t4, e, den, v;
    for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
      zc = $signed((64'(2 * k + 1) << 27) / SIGMOID_ENTRIES) - (64'sd1 <<< 27);
      a  = (zc < 0) ? 64'(-zc) : 64'(zc);
      d  = a >> 2;
      t2 = (d * d) >> 30;
      t3 = (t2 * d) >> 30;
      t4 = (t3 * d) >> 30;
      e  = (64'd1 << 30) - d + (t2 >> 1) - t3 / 64'd6 + t4 / 64'd24;
      for (int n = 0; n < 8; n++) begin
        e = (e * e + (64'd1 << 29)) >> 30;
      end
      den = (64'd1 << 30) + e;
      if (zc >= 0) begin
        v = udiv64((64'd1 << 54) + (den >> 1), den);
      end else begin
        v = udiv64((e << 24) + (den >> 1), den);
      end
      tab[k] = v[24:0];
    end
    return tab;
  endfunction

  localparam sig_table_t SIG_TABLE = sig_table_f();

endpackage

// ===== rtl/core/hcpg_if.sv =====
// Beat channels of the pattern generator: command, result and config write.
// Depends on hcpg_pkg.
`timescale 1ns / 1ps

interface hcpg_in_if import hcpg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [ROW_W-1:0]        target_row;
  logic [ROW_W-1:0]        source_col;
  logic signed [VAL_W-1:0] value_a;
  logic signed [VAL_W-1:0] value_b;
  modport source(output valid, operation, target_row, source_col, value_a, value_b,
                 input ready);
  modport sink(input valid, operation, target_row, source_col, value_a, value_b,
               output ready);
endinterface

interface hcpg_out_if import hcpg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ROW_W-1:0]        osc_index;
  logic signed [VAL_W-1:0] pos_x;
  logic signed [VAL_W-1:0] pos_y;
  logic                    last;
  modport source(output valid, osc_index, pos_x, pos_y, last, input ready);
  modport sink(input valid, osc_index, pos_x, pos_y, last, output ready);
endinterface

interface hcpg_cfg_if import hcpg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CDAT_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/hcpg_divider.sv =====
// Restoring serial divider, one quotient bit per cycle, for the stance rate.
// Depends on hcpg_pkg.
`timescale 1ns / 1ps

module hcpg_divider import hcpg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic [DIV_NW-1:0] quo,
  output logic              done
);

  logic [DIV_DW-1:0] rem;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic [DIV_DW:0]   sh;
  logic [DIV_DW:0]   trial;

  assign sh    = {rem, quo[DIV_NW-1]};
  assign trial = sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      if (sh >= {1'b0, den}) begin
        rem <= trial[DIV_DW-1:0];
        quo <= {quo[DIV_NW-2:0], 1'b1};
      end else begin
        rem <= sh[DIV_DW-1:0];
        quo <= {quo[DIV_NW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/core/coupled_hopf_cpg_network_step_unit.sv =====
// Top level of the coupled Hopf pattern generator: sequencer, state and
// coupling memories, shared multiply-accumulate. Depends on hcpg_pkg,
// hcpg_if and hcpg_divider.
//
// A tick command advances all oscillators one Euler step from the old state
// and returns one result beat per oscillator in index order, last set on the
// final one. A tick runs the set-up steps and the serial stance-rate divider,
// then each oscillator in turn on the one shared multiplier (12 products for
// the self terms and step, 4 per coupling source, each source read from both
// memories). Results stall the sequencer only while the output register is
// still full. New state goes to the other half of the double-banked state
// memory and the banks swap after the last beat. Config writes are always
// ready.
`timescale 1ns / 1ps

module coupled_hopf_cpg_network_step_unit import hcpg_pkg::*; (
  input logic        clk,
  input logic        rst,
  hcpg_in_if.sink    items,
  hcpg_out_if.source results,
  hcpg_cfg_if.sink   cfg
);

  state_t  state, state_next;
  mul_op_t mul_op, acc_op;
  logic [3:0] step, step_next;

  logic [OSC_IW-1:0] osc, jj;
  logic [CP_AW-1:0]  cp_base;
  logic              bank;
  logic              osc_last;

  logic [15:0] swing_rate, duty_factor;
  logic [23:0] step_size;

  logic in_accept, out_load, out_valid, div_start, div_done;

  // memories
  logic [63:0]         st_mem [ST_DEPTH];
  logic [63:0]         cp_mem [CP_DEPTH];
  logic [ST_DEPTH-1:0] st_valid;
  logic [CP_DEPTH-1:0] cp_valid;
  logic [ST_AW-1:0]    st_raddr, st_waddr;
  logic [CP_AW-1:0]    cp_raddr, cp_waddr;
  logic [63:0]         st_rdata, cp_rdata, st_wdata;
  logic                st_rok, cp_rok, st_we, cp_we;
  logic [31:0]         st_x_rd, st_y_rd, cp_c_rd, cp_s_rd;

  // datapath
  logic [31:0]        wsw_reg, wst_reg, w_reg, a_reg;
  logic [47:0]        num_reg;
  logic [DIV_NW-1:0]  div_quo;
  logic [16:0]        beta, beta_inv;
  logic [24:0]        s_reg, s_inv;
  logic signed [31:0] xi, yi, cj, sj, xj, yj, res_x, res_y;
  logic signed [39:0] dxc, dyc;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic [63:0]        r2acc;
  logic [57:0]        wacc;
  logic signed [47:0] dxacc, dyacc, fext, f100;
  logic signed [64:0] hx, hy;

  logic signed [37:0]  t_sig;
  logic [49:0]         t_scaled;
  logic [SIG_AW-1:0]   k_idx;
  logic signed [40:0]  a_diff;
  logic [31:0]         a_next, w_next;
  logic signed [41:0]  sum_x, sum_y;
  logic signed [39:0]  dxc_next, dyc_next;

  assign in_accept   = items.valid && items.ready;
  assign items.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign results.valid = out_valid;
  assign out_load    = (state == S_EMIT) && (!out_valid || results.ready);
  assign osc_last    = (osc == OSC_IW'(NUM_OSC - 1));

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    mul_op     = MOP_NONE;
    div_start  = 1'b0;
    st_raddr   = bank ? ST_AW'(NUM_OSC + int'(osc)) : ST_AW'(osc);
    cp_raddr   = cp_base + CP_AW'(jj);
    case (state)
      S_IDLE: begin
        if (in_accept && items.operation == OP_TICK) begin
          state_next = S_PREP;
          step_next  = '0;
        end
      end
      S_PREP: begin
        step_next = step + 1'b1;
        if (step == 4'd2) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) state_next = S_SELF_RD;
      end
      S_SELF_RD: state_next = S_SELF_LT;
      S_SELF_LT: begin
        state_next = S_CALC;
        step_next  = '0;
      end
      S_CALC: begin
        step_next = step + 1'b1;
        case (step)
          4'd0: mul_op = MOP_XX;
          4'd1: mul_op = MOP_YY;
          4'd3: mul_op = MOP_WST;
          4'd4: mul_op = MOP_WSW;
          4'd5: mul_op = MOP_AX;
          4'd6: mul_op = MOP_AY;
          4'd7: mul_op = MOP_WY;
          4'd8: begin
            mul_op     = MOP_WX;
            state_next = S_CP_RD;
          end
          default: mul_op = MOP_NONE;
        endcase
      end
      S_CP_RD: begin
        st_raddr   = bank ? ST_AW'(NUM_OSC + int'(jj)) : ST_AW'(jj);
        state_next = S_CP_LT;
      end
      S_CP_LT: begin
        state_next = S_CP_MUL;
        step_next  = '0;
      end
      S_CP_MUL: begin
        step_next = step + 1'b1;
        case (step)
          4'd0: mul_op = MOP_CX;
          4'd1: mul_op = MOP_SY;
          4'd2: mul_op = MOP_SX;
          default: begin
            mul_op = MOP_CY;
            if (jj == OSC_IW'(NUM_OSC - 1)) begin
              state_next = S_FIN;
              step_next  = '0;
            end else begin
              state_next = S_CP_RD;
            end
          end
        endcase
      end
      S_FIN: begin
        step_next = step + 1'b1;
        if (step == 4'd1) begin
          state_next = S_H_MUL;
          step_next  = '0;
        end
      end
      S_H_MUL: begin
        step_next = step + 1'b1;
        case (step)
          4'd0: mul_op = MOP_DXH_HI;
          4'd1: mul_op = MOP_DXH_LO;
          4'd2: mul_op = MOP_DYH_HI;
          default: begin
            mul_op     = MOP_DYH_LO;
            state_next = S_SUM;
            step_next  = '0;
          end
        endcase
      end
      S_SUM: begin
        step_next = step + 1'b1;
        if (step == 4'd1) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) state_next = osc_last ? S_IDLE : S_SELF_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      osc     <= '0;
      jj      <= '0;
      cp_base <= '0;
      bank    <= 1'b0;
    end else begin
      if (state == S_DIV && div_done) begin
        osc     <= '0;
        cp_base <= '0;
      end
      if (state == S_CALC && step == 4'd8) jj <= '0;
      if (state == S_CP_MUL && step == 4'd3 && jj != OSC_IW'(NUM_OSC - 1)) jj <= jj + 1'b1;
      if (out_load) begin
        if (osc_last) begin
          bank <= ~bank;
        end else begin
          osc     <= osc + 1'b1;
          cp_base <= cp_base + CP_AW'(NUM_OSC);
        end
      end
    end
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      swing_rate  <= 16'd8192;
      duty_factor <= 16'd32768;
      step_size   <= 24'd16777;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SWING: swing_rate  <= cfg.data[15:0];
        CFG_DUTY:  duty_factor <= cfg.data[15:0];
        CFG_STEP:  step_size   <= cfg.data;
        default: ;
      endcase
    end
  end

  // ---------------- memories ----------------
  always_comb begin
    st_we    = 1'b0;
    st_waddr = '0;
    st_wdata = {res_x, res_y};
    cp_we    = 1'b0;
    cp_waddr = CP_AW'(int'(items.target_row) * NUM_OSC + int'(items.source_col));
    if (in_accept && items.operation == OP_STATE && int'(items.target_row) < NUM_OSC) begin
      st_we    = 1'b1;
      st_waddr = bank ? ST_AW'(NUM_OSC + int'(items.target_row))
                      : ST_AW'(items.target_row);
      st_wdata = {items.value_a, items.value_b};
    end else if (out_load) begin
      st_we    = 1'b1;
      st_waddr = bank ? ST_AW'(osc) : ST_AW'(NUM_OSC + int'(osc));
    end
    if (in_accept && items.operation == OP_COUPLE && int'(items.target_row) < NUM_OSC &&
        int'(items.source_col) < NUM_OSC) begin
      cp_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    if (cp_we) cp_mem[cp_waddr] <= {items.value_a, items.value_b};
    st_rdata <= st_mem[st_raddr];
    cp_rdata <= cp_mem[cp_raddr];
    st_rok   <= st_valid[st_raddr];
    cp_rok   <= cp_valid[cp_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
      cp_valid <= '0;
    end else begin
      if (st_we) st_valid[st_waddr] <= 1'b1;
      if (cp_we) cp_valid[cp_waddr] <= 1'b1;
    end
  end

  assign st_x_rd = st_rok ? st_rdata[63:32] : '0;
  assign st_y_rd = st_rok ? st_rdata[31:0]  : '0;
  assign cp_c_rd = cp_rok ? cp_rdata[63:32] : '0;
  assign cp_s_rd = cp_rok ? cp_rdata[31:0]  : '0;

  // ---------------- rate set-up ----------------
  assign beta     = (duty_factor == 16'd0) ? 17'd1 : {1'b0, duty_factor};
  assign beta_inv = 17'h10000 - beta;

  hcpg_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_reg),
    .den   (beta[DIV_DW-1:0]),
    .quo   (div_quo),
    .done  (div_done)
  );

  // ---------------- derived values ----------------
  always_comb begin
    t_sig    = ($signed({{6{yi[31]}}, yi}) <<< 3) + ($signed({{6{yi[31]}}, yi}) <<< 1)
               + 38'sd134217728;
    t_scaled = 50'(t_sig[36:0]) * 50'(SIGMOID_ENTRIES);
    if (t_sig <= 0) begin
      k_idx = '0;
    end else if (t_scaled[49:28] > 22'(SIGMOID_ENTRIES - 1)) begin
      k_idx = SIG_AW'(SIGMOID_ENTRIES - 1);
    end else begin
      k_idx = t_scaled[SIG_AW+27:28];
    end
    s_inv  = 25'h1000000 - s_reg;
    a_diff = 41'sd16777216 - $signed({1'b0, r2acc[63:24]});
    a_next = (a_diff < -41'sd2147483648) ? 32'h8000_0000 : a_diff[31:0];
    w_next = (wacc[57:56] != 2'b00) ? 32'hFFFF_FFFF : wacc[55:24];
    dxc_next = (dxacc > 48'sd549755813887) ? 40'sh7F_FFFF_FFFF :
               (dxacc < -48'sd549755813888) ? 40'sh80_0000_0000 : dxacc[39:0];
    dyc_next = (dyacc > 48'sd549755813887) ? 40'sh7F_FFFF_FFFF :
               (dyacc < -48'sd549755813888) ? 40'sh80_0000_0000 : dyacc[39:0];
    sum_x = {hx[64], hx[64:24]} + {{10{xi[31]}}, xi};
    sum_y = {hy[64], hy[64:24]} + {{10{yi[31]}}, yi};
  end

  always_ff @(posedge clk) begin
    if (state == S_PREP && step == 4'd0) wsw_reg <= 32'((44'(swing_rate) * 44'(THREE_PI_Q24)) >> 12);
    if (state == S_PREP && step == 4'd1) num_reg <= 48'(wsw_reg) * 48'(beta_inv);
    if (state == S_DIV && div_done) begin
      wst_reg <= (div_quo[47:32] != 16'd0) ? 32'hFFFF_FFFF : div_quo[31:0];
    end
    if (state == S_SELF_LT) begin
      xi <= st_x_rd;
      yi <= st_y_rd;
    end
    if (state == S_CALC && step == 4'd2) s_reg <= SIG_TABLE[k_idx];
    if (state == S_CALC && step == 4'd3) a_reg <= a_next;
    if (state == S_CALC && step == 4'd6) w_reg <= w_next;
    if (state == S_CP_LT) begin
      cj <= cp_c_rd;
      sj <= cp_s_rd;
      xj <= st_x_rd;
      yj <= st_y_rd;
    end
    if (state == S_FIN && step == 4'd1) begin
      dxc <= dxc_next;
      dyc <= dyc_next;
    end
    if (state == S_SUM && step == 4'd1) begin
      res_x <= (sum_x > 42'sd2147483647) ? 32'sh7FFF_FFFF :
               (sum_x < -42'sd2147483648) ? 32'sh8000_0000 : sum_x[31:0];
      res_y <= (sum_y > 42'sd2147483647) ? 32'sh7FFF_FFFF :
               (sum_y < -42'sd2147483648) ? 32'sh8000_0000 : sum_y[31:0];
    end
  end

  // ---------------- shared multiply-accumulate ----------------
  always_comb begin
    ma = '0;
    mb = '0;
    case (mul_op)
      MOP_XX:     begin ma = {xi[31], xi}; mb = {xi[31], xi}; end
      MOP_YY:     begin ma = {yi[31], yi}; mb = {yi[31], yi}; end
      MOP_WST:    begin ma = {1'b0, wst_reg}; mb = {8'd0, s_reg}; end
      MOP_WSW:    begin ma = {1'b0, wsw_reg}; mb = {8'd0, s_inv}; end
      MOP_AX:     begin ma = {a_reg[31], a_reg}; mb = {xi[31], xi}; end
      MOP_AY:     begin ma = {a_reg[31], a_reg}; mb = {yi[31], yi}; end
      MOP_WY:     begin ma = {1'b0, w_reg}; mb = {yi[31], yi}; end
      MOP_WX:     begin ma = {1'b0, w_reg}; mb = {xi[31], xi}; end
      MOP_CX:     begin ma = {cj[31], cj}; mb = {xj[31], xj}; end
      MOP_SY:     begin ma = {sj[31], sj}; mb = {yj[31], yj}; end
      MOP_SX:     begin ma = {sj[31], sj}; mb = {xj[31], xj}; end
      MOP_CY:     begin ma = {cj[31], cj}; mb = {yj[31], yj}; end
      MOP_DXH_HI: begin ma = {{13{dxc[39]}}, dxc[39:20]}; mb = {9'd0, step_size}; end
      MOP_DXH_LO: begin ma = {13'd0, dxc[19:0]}; mb = {9'd0, step_size}; end
      MOP_DYH_HI: begin ma = {{13{dyc[39]}}, dyc[39:20]}; mb = {9'd0, step_size}; end
      MOP_DYH_LO: begin ma = {13'd0, dyc[19:0]}; mb = {9'd0, step_size}; end
      default: ;
    endcase
  end

  assign fext = {{6{prod[65]}}, prod[65:24]};
  assign f100 = (fext <<< 6) + (fext <<< 5) + (fext <<< 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_op <= MOP_NONE;
    end else begin
      acc_op <= mul_op;
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (state == S_SELF_LT) begin
      r2acc <= '0;
      wacc  <= '0;
      dxacc <= '0;
      dyacc <= '0;
      hx    <= '0;
      hy    <= '0;
    end else begin
      case (acc_op)
        MOP_XX, MOP_YY:   r2acc <= r2acc + prod[63:0];
        MOP_WST, MOP_WSW: wacc  <= wacc + prod[57:0];
        MOP_AX:           dxacc <= dxacc + f100;
        MOP_AY:           dyacc <= dyacc + f100;
        MOP_WY, MOP_SY:   dxacc <= dxacc - fext;
        MOP_CX:           dxacc <= dxacc + fext;
        MOP_WX, MOP_SX, MOP_CY: dyacc <= dyacc + fext;
        MOP_DXH_HI:       hx <= hx + (prod[64:0] <<< 20);
        MOP_DXH_LO:       hx <= hx + prod[64:0];
        MOP_DYH_HI:       hy <= hy + (prod[64:0] <<< 20);
        MOP_DYH_LO:       hy <= hy + prod[64:0];
        default: ;
      endcase
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.osc_index <= ROW_W'(osc);
      results.pos_x     <= res_x;
      results.pos_y     <= res_y;
      results.last      <= osc_last;
    end
  end

  // ---------------- assertions ----------------
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.last |-> results.osc_index == ROW_W'(NUM_OSC - 1))
    else $error("last beat not on final oscillator");

  a_bank_swap: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (bank != $past(bank)) |-> $past(out_load && osc_last))
    else $error("state bank swapped outside end of tick");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside set-up");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && !out_load |=> state == S_EMIT && $stable(res_x) && $stable(res_y))
    else $error("pending result lost while output full");

endmodule
